@@ hw/rtl/sitp_pkg.sv @@
// Shared types, constants and helper functions for the sized integer text parser.
// No dependencies; imported by sitp_core, sized_integer_text_parser and sitp_checker.
`default_nettype none

package sitp_pkg;

  // Width of the internal consumed-character counter
  localparam int COUNT_BITS = 16;

  // Configuration register indexes
  localparam logic [1:0] CFG_BASE_SELECT = 2'd0;
  localparam logic [1:0] CFG_SIZE_CLASS  = 2'd1;
  localparam logic [1:0] CFG_SIGNED_MODE = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_NONDIGIT = 2'd0;
  localparam logic [1:0] ST_END      = 2'd1;
  localparam logic [1:0] ST_LIMIT    = 2'd2;
  localparam logic [1:0] ST_BADBASE  = 2'd3;

  // Marker for "not a digit" from digit_of
  localparam logic [4:0] NO_DIGIT = 5'd16;

  // Digit limit per size class (rows) and base 2..16 (columns)
  localparam logic [6:0] DIGIT_LIMIT [4][15] = '{
    '{7'd8,  7'd6,  7'd4,  7'd4,  7'd4,  7'd3,  7'd3,  7'd3,
      7'd3,  7'd3,  7'd3,  7'd3,  7'd3,  7'd3,  7'd2},
    '{7'd16, 7'd11, 7'd8,  7'd7,  7'd7,  7'd6,  7'd6,  7'd6,
      7'd5,  7'd5,  7'd5,  7'd5,  7'd5,  7'd5,  7'd4},
    '{7'd32, 7'd21, 7'd16, 7'd14, 7'd13, 7'd12, 7'd11, 7'd11,
      7'd10, 7'd10, 7'd9,  7'd9,  7'd9,  7'd9,  7'd8},
    '{7'd64, 7'd41, 7'd32, 7'd28, 7'd25, 7'd23, 7'd22, 7'd21,
      7'd20, 7'd19, 7'd18, 7'd18, 7'd17, 7'd17, 7'd16}
  };

  // One result transaction from the parse step
  typedef struct packed {
    logic        valid;
    logic [63:0] value;
    logic [15:0] consumed;
    logic [6:0]  digits_taken;
    logic [1:0]  status;
  } sitp_res_t;

  // Hex digit value of an ASCII character, NO_DIGIT if none
  function automatic logic [4:0] digit_of(input logic [7:0] c);
    logic [4:0] d;
    d = NO_DIGIT;
    if (c >= "0" && c <= "9") d = 5'(c - 8'h30);
    else if (c >= "a" && c <= "f") d = 5'(c - 8'h57);
    else if (c >= "A" && c <= "F") d = 5'(c - 8'h37);
    return d;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/sitp_core.sv @@
// Per-character parse step: string state registers and the combinational step.
// Depends on sitp_pkg.
`default_nettype none

module sitp_core (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  step_en,
  input  wire logic [7:0]            char_in,
  input  wire logic                  last_char,
  input  wire logic [4:0]            base_select,
  input  wire logic [2:0]            size_class,
  input  wire logic                  signed_mode,
  output sitp_pkg::sitp_res_t        res
);
  import sitp_pkg::*;

  typedef enum logic [2:0] {
    PH_START,
    PH_AFTER_SIGN,
    PH_SAW_ZERO,
    PH_DIGITS,
    PH_DRAIN
  } phase_t;

  phase_t                phase_r, phase_nxt;
  logic [63:0]           acc_r, acc_nxt;
  logic [6:0]            dcnt_r, dcnt_nxt;
  logic [COUNT_BITS-1:0] ccnt_r, ccnt_nxt;
  logic                  neg_r, neg_nxt;
  logic [4:0]            base_r, base_nxt;

  // Effective size class, 1..4 encoded as 0..3
  logic [1:0] size_idx;
  always_comb begin
    if (size_class == 3'd0)      size_idx = 2'd0;
    else if (size_class > 3'd4)  size_idx = 2'd3;
    else                         size_idx = 2'(size_class - 3'd1);
  end

  // Parse step
  always_comb begin
    logic        do_sign_done;
    logic        do_zero_done;
    logic        do_digit;
    logic        emit;
    logic [1:0]  st;
    logic [4:0]  d;
    logic [63:0] v;
    logic [31:0] cnt32;

    phase_nxt    = phase_r;
    acc_nxt      = acc_r;
    dcnt_nxt     = dcnt_r;
    ccnt_nxt     = ccnt_r;
    neg_nxt      = neg_r;
    base_nxt     = base_r;
    do_sign_done = 1'b0;
    do_zero_done = 1'b0;
    do_digit     = 1'b0;
    emit         = 1'b0;
    st           = ST_NONDIGIT;
    d            = NO_DIGIT;

    unique case (phase_r)
      PH_START: begin
        if (base_select == 5'd1 || base_select > 5'd16) begin
          emit = 1'b1;
          st   = ST_BADBASE;
        end else begin
          base_nxt = base_select;
          if (signed_mode && char_in == "-") begin
            neg_nxt   = 1'b1;
            ccnt_nxt  = (ccnt_r == '1) ? ccnt_r : ccnt_r + 1'b1;
            phase_nxt = PH_AFTER_SIGN;
            emit      = last_char;
            st        = ST_END;
          end else begin
            do_sign_done = 1'b1;
          end
        end
      end
      PH_AFTER_SIGN: do_sign_done = 1'b1;
      PH_SAW_ZERO:   do_zero_done = 1'b1;
      PH_DIGITS:     do_digit     = 1'b1;
      default: begin
        // drain the rest of the string after a result
        phase_nxt = PH_DRAIN;
      end
    endcase

    // After the sign: with automatic base look for the leading zero of a hex prefix, else go to the digits
    if (do_sign_done) begin
      if (base_nxt == 5'd0) begin
        if (char_in == "0") begin
          ccnt_nxt  = (ccnt_r == '1) ? ccnt_r : ccnt_r + 1'b1;
          phase_nxt = PH_SAW_ZERO;
          emit      = last_char;
          st        = ST_END;
        end else begin
          base_nxt = 5'd10;
          do_digit = 1'b1;
        end
      end else begin
        do_digit = 1'b1;
      end
    end

    // Prefix 'x' after the zero
    if (do_zero_done) begin
      if (char_in == "x" || char_in == "X") begin
        base_nxt  = 5'd16;
        ccnt_nxt  = (ccnt_r == '1) ? ccnt_r : ccnt_r + 1'b1;
        phase_nxt = PH_DIGITS;
        emit      = last_char;
        st        = ST_END;
      end else begin
        base_nxt = 5'd10;
        do_digit = 1'b1;
      end
    end

    // Digit accumulation
    if (do_digit) begin
      phase_nxt = PH_DIGITS;
      if (base_nxt < 5'd2 || base_nxt > 5'd16) base_nxt = 5'd10;
      d = digit_of(char_in);
      if (d >= base_nxt) begin
        emit = 1'b1;
        st   = ST_NONDIGIT;
      end else begin
        ccnt_nxt = (ccnt_r == '1) ? ccnt_r : ccnt_r + 1'b1;
        if (d != 5'd0 || dcnt_r != 7'd0) begin
          acc_nxt  = 64'(acc_r * {59'd0, base_nxt}) + {59'd0, d};
          dcnt_nxt = dcnt_r + 7'd1;
          if (dcnt_nxt >= DIGIT_LIMIT[size_idx][4'(base_nxt - 5'd2)]) begin
            emit = 1'b1;
            st   = ST_LIMIT;
          end else begin
            emit = last_char;
            st   = ST_END;
          end
        end else begin
          emit = last_char;
          st   = ST_END;
        end
      end
    end

    // Format the result from the updated state
    v = neg_nxt ? (64'd0 - acc_nxt) : acc_nxt;
    unique case (size_idx)
      2'd0: v = signed_mode ? {{56{v[7]}}, v[7:0]} : {56'd0, v[7:0]};
      2'd1: v = signed_mode ? {{48{v[15]}}, v[15:0]} : {48'd0, v[15:0]};
      2'd2: v = signed_mode ? {{32{v[31]}}, v[31:0]} : {32'd0, v[31:0]};
      default: v = v;
    endcase
    cnt32 = 32'(ccnt_nxt);

    res.valid        = step_en && emit;
    res.status       = st;
    res.value        = (st == ST_BADBASE) ? 64'd0 : v;
    res.consumed     = (st == ST_BADBASE) ? 16'd0 :
                       (cnt32 > 32'h0000_FFFF) ? 16'hFFFF : cnt32[15:0];
    res.digits_taken = (st == ST_BADBASE) ? 7'd0 : dcnt_nxt;

    // A result ends the string, or drains it until the last character
    if (phase_r == PH_DRAIN) begin
      if (last_char) begin
        phase_nxt = PH_START;
        acc_nxt   = '0;
        dcnt_nxt  = '0;
        ccnt_nxt  = '0;
        neg_nxt   = 1'b0;
        base_nxt  = '0;
      end
    end else if (emit) begin
      if (last_char) begin
        phase_nxt = PH_START;
        acc_nxt   = '0;
        dcnt_nxt  = '0;
        ccnt_nxt  = '0;
        neg_nxt   = 1'b0;
        base_nxt  = '0;
      end else begin
        phase_nxt = PH_DRAIN;
      end
    end
  end

  // String state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_START;
      acc_r   <= '0;
      dcnt_r  <= '0;
      ccnt_r  <= '0;
      neg_r   <= 1'b0;
      base_r  <= '0;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      dcnt_r  <= dcnt_nxt;
      ccnt_r  <= ccnt_nxt;
      neg_r   <= neg_nxt;
      base_r  <= base_nxt;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/sized_integer_text_parser.sv @@
// Sized integer text parser: one character per cycle in unless stalled, one number
// per string out. A character passes an input register, one parse step in sitp_core,
// then the output register; the parse state is updated in that same step, so a new
// character can be taken every cycle. The rate is set by the combinational parse
// step (multiply-add of the accumulator by the base). While a result waits the parse
// step holds, and the input register takes one more character before input stalls.
// Configuration is written on cfg_we with no wait.
// Depends on sitp_pkg and sitp_core.
`default_nettype none

module sized_integer_text_parser (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_char_in,
  input  wire logic        in_last_char,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [63:0]      out_value,
  output logic [15:0]      out_consumed,
  output logic [6:0]       out_digits_taken,
  output logic [1:0]       out_status,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [4:0]  cfg_wdata
);
  import sitp_pkg::*;

  logic [4:0] base_select_r;
  logic [2:0] size_class_r;
  logic       signed_mode_r;

  logic       in_valid_r;
  logic [7:0] in_char_r;
  logic       in_last_r;

  logic       out_valid_r;
  logic [63:0] out_value_r;
  logic [15:0] out_consumed_r;
  logic [6:0]  out_digits_r;
  logic [1:0]  out_status_r;

  logic       step_en;
  sitp_res_t  res;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_select_r <= 5'd10;
      size_class_r  <= 3'd4;
      signed_mode_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BASE_SELECT: base_select_r <= cfg_wdata;
        CFG_SIZE_CLASS:  size_class_r  <= cfg_wdata[2:0];
        CFG_SIGNED_MODE: signed_mode_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Step when a character is held and the output register can take a result
  assign step_en  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || step_en;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_char_r <= in_char_in;
      in_last_r <= in_last_char;
    end
  end

  sitp_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_en     (step_en),
    .char_in     (in_char_r),
    .last_char   (in_last_r),
    .base_select (base_select_r),
    .size_class  (size_class_r),
    .signed_mode (signed_mode_r),
    .res         (res)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      out_value_r    <= res.value;
      out_consumed_r <= res.consumed;
      out_digits_r   <= res.digits_taken;
      out_status_r   <= res.status;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_value        = out_value_r;
  assign out_consumed     = out_consumed_r;
  assign out_digits_taken = out_digits_r;
  assign out_status       = out_status_r;

endmodule

`default_nettype wire

@@ hw/rtl/sitp_checker.sv @@
// Port-level checks for sized_integer_text_parser, attached by bind.
// Depends on sitp_pkg.
`default_nettype none

module sitp_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [63:0] out_value,
  input wire logic [15:0] out_consumed,
  input wire logic [6:0]  out_digits_taken,
  input wire logic [1:0]  out_status
);
  import sitp_pkg::*;

  // Invalid base reports an empty result
  a_badbase_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_BADBASE |->
      out_value == 64'd0 && out_consumed == 16'd0 && out_digits_taken == 7'd0)
    else $error("invalid-base result not empty");

  // Digit limit needs at least one significant digit, at most 64
  a_limit_digits: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_LIMIT |->
      out_digits_taken != 7'd0 && out_digits_taken <= 7'd64)
    else $error("digit-limit result with bad digit count");

  // Every significant digit is a consumed character
  a_digits_consumed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> {9'd0, out_digits_taken} <= out_consumed)
    else $error("more digits than consumed characters");

  // A stalled result transaction stays valid and holds its value and status
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_status))
    else $error("result changed while stalled");

endmodule

bind sized_integer_text_parser sitp_checker u_sitp_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_value        (out_value),
  .out_consumed     (out_consumed),
  .out_digits_taken (out_digits_taken),
  .out_status       (out_status)
);

`default_nettype wire
